// ===== src/lzfd_pkg.sv =====
// Package for the fixed-code LZ77 decompressor: sizes, phase codes,
// length/distance tables and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package lzfd_pkg;

    localparam int WINDOW_BYTES = 32768;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);
    localparam int OUT_LANES    = 8;
    localparam int LANE_IW      = $clog2(OUT_LANES);
    localparam int CNT_W        = $clog2(OUT_LANES + 1);
    localparam int MAX_MATCH    = 258;
    localparam int STAGE_CAP    = 272;
    localparam int STAGE_W      = $clog2(STAGE_CAP + 1);
    localparam int PROD_W       = 16;
    localparam int DIST_W       = 16;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_SYM  = 2'd1;
    localparam logic [1:0] ERR_DCODE = 2'd2;
    localparam logic [1:0] ERR_FAR  = 2'd3;

    // decode phase of the bit stream
    typedef enum logic [6:0] {
        PH_HEADER     = 7'b0000001,
        PH_CODE       = 7'b0000010,
        PH_LEN_EXTRA  = 7'b0000100,
        PH_DIST_CODE  = 7'b0001000,
        PH_DIST_EXTRA = 7'b0010000,
        PH_DONE       = 7'b0100000,
        PH_HALT       = 7'b1000000
    } phase_t;

    // commands from the controller
    typedef struct packed {
        logic load;    // input transaction this cycle
        logic step;    // run one decode phase
        logic cpy_rd;  // copy: history read in flight
        logic cpy_wr;  // copy: emit one byte
        logic flush;   // end of input byte: close the result
    } lzfd_cmd_t;

    // status to the controller
    typedef struct packed {
        logic load_go;    // accepted byte needs decoding
        logic step_end;   // not enough bits, or stream ended or halted
        logic step_copy;  // match accepted, copy starts
        logic put_ok;     // a byte can be stored this cycle
        logic copy_last;  // current copy byte is the final one
        logic flush_done; // closing result has been handed off
    } lzfd_stat_t;

    function automatic logic [8:0] len_base(input logic [4:0] idx);
        logic [8:0] r;
        begin
            case (idx)
                5'd0: r = 9'd3;    5'd1: r = 9'd4;    5'd2: r = 9'd5;
                5'd3: r = 9'd6;    5'd4: r = 9'd7;    5'd5: r = 9'd8;
                5'd6: r = 9'd9;    5'd7: r = 9'd10;   5'd8: r = 9'd11;
                5'd9: r = 9'd13;   5'd10: r = 9'd15;  5'd11: r = 9'd17;
                5'd12: r = 9'd19;  5'd13: r = 9'd23;  5'd14: r = 9'd27;
                5'd15: r = 9'd31;  5'd16: r = 9'd35;  5'd17: r = 9'd43;
                5'd18: r = 9'd51;  5'd19: r = 9'd59;  5'd20: r = 9'd67;
                5'd21: r = 9'd83;  5'd22: r = 9'd99;  5'd23: r = 9'd115;
                5'd24: r = 9'd131; 5'd25: r = 9'd163; 5'd26: r = 9'd195;
                5'd27: r = 9'd227; 5'd28: r = 9'd258;
                default: r = 9'd3;
            endcase
            return r;
        end
    endfunction

    function automatic logic [3:0] len_extra(input logic [4:0] idx);
        logic [3:0] r;
        begin
            if (idx < 5'd8 || idx == 5'd28) begin
                r = 4'd0;
            end else if (idx > 5'd28) begin
                r = 4'd0;
            end else begin
                r = 4'(({1'b0, idx} - 6'd4) >> 2);
            end
            return r;
        end
    endfunction

    function automatic logic [15:0] dist_base(input logic [4:0] idx);
        logic [15:0] r;
        begin
            case (idx)
                5'd0: r = 16'd1;      5'd1: r = 16'd2;      5'd2: r = 16'd3;
                5'd3: r = 16'd4;      5'd4: r = 16'd5;      5'd5: r = 16'd7;
                5'd6: r = 16'd9;      5'd7: r = 16'd13;     5'd8: r = 16'd17;
                5'd9: r = 16'd25;     5'd10: r = 16'd33;    5'd11: r = 16'd49;
                5'd12: r = 16'd65;    5'd13: r = 16'd97;    5'd14: r = 16'd129;
                5'd15: r = 16'd193;   5'd16: r = 16'd257;   5'd17: r = 16'd385;
                5'd18: r = 16'd513;   5'd19: r = 16'd769;   5'd20: r = 16'd1025;
                5'd21: r = 16'd1537;  5'd22: r = 16'd2049;  5'd23: r = 16'd3073;
                5'd24: r = 16'd4097;  5'd25: r = 16'd6145;  5'd26: r = 16'd8193;
                5'd27: r = 16'd12289; 5'd28: r = 16'd16385; 5'd29: r = 16'd24577;
                default: r = 16'd1;
            endcase
            return r;
        end
    endfunction

    function automatic logic [3:0] dist_extra(input logic [4:0] idx);
        logic [3:0] r;
        begin
            if (idx < 5'd4 || idx > 5'd29) begin
                r = 4'd0;
            end else begin
                r = 4'((idx - 5'd2) >> 1);
            end
            return r;
        end
    endfunction

endpackage

// ===== src/lzfd_ram.sv =====
// Generic single-write, single-read RAM with registered read (old data on
// a same-address write). No dependencies.
`timescale 1ns / 1ps

module lzfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/lzfd_ctrl.sv =====
// Sequencing controller: input transaction, decode steps, match copy and
// result close-out. Depends on lzfd_pkg.
`timescale 1ns / 1ps

module lzfd_ctrl
    import lzfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  lzfd_stat_t stat,
    output lzfd_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_STEP   = 5'b00010,
        ST_CPY_RD = 5'b00100,
        ST_CPY_WR = 5'b01000,
        ST_FLUSH  = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid && stat.load_go) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (stat.step_end) begin
                    state_next = ST_FLUSH;
                end else if (stat.step_copy) begin
                    state_next = ST_CPY_RD;
                end
            end
            ST_CPY_RD: begin
                cmd.cpy_rd = 1'b1;
                state_next = ST_CPY_WR;
            end
            ST_CPY_WR: begin
                cmd.cpy_wr = 1'b1;
                if (stat.put_ok) begin
                    state_next = stat.copy_last ? ST_STEP : ST_CPY_RD;
                end
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
                if (stat.flush_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ===== src/lzfd_datapath.sv =====
// Datapath: bit buffer and symbol decode, match copy over the history RAM,
// byte packing and the output register. Depends on lzfd_pkg, lzfd_ram.
`timescale 1ns / 1ps

module lzfd_datapath
    import lzfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  lzfd_cmd_t   cmd,
    output lzfd_stat_t  stat,
    input  logic [7:0]  in_byte,
    input  logic        in_start,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    // stream state
    logic [23:0]             buf_reg;
    logic [4:0]              held_reg;
    phase_t                  phase_reg;
    logic [4:0]              len_idx_reg;
    logic [8:0]              mlen_reg;
    logic [4:0]              dist_idx_reg;
    logic [WIN_AW-1:0]       wr_idx_reg;
    logic [PROD_W-1:0]       prod_reg;
    // copy state
    logic [DIST_W-1:0]       dist_reg;
    logic [8:0]              cpy_i_reg;
    logic [WIN_AW-1:0]       src_reg;
    logic [7:0]              last_byte_reg;
    // per-byte result state
    logic [7:0]              lanes_reg [OUT_LANES];
    logic [CNT_W-1:0]        pack_cnt_reg;
    logic [STAGE_W-1:0]      stage_cnt_reg;
    logic                    done_reg;
    logic [1:0]              err_reg;
    // output register
    logic                    o_valid_reg;
    logic [8*OUT_LANES-1:0]  o_data_reg;
    logic [CNT_W-1:0]        o_cnt_reg;
    logic                    o_done_reg;
    logic [1:0]              o_err_reg;
    logic                    o_last_reg;

    logic [7:0]              ram_rd;
    logic [WIN_AW-1:0]       ram_raddr;

    // ---------------- decode of one phase ----------------
    logic [23:0]        aligned;
    logic [8:0]         top9;
    logic [12:0]        ext13;
    logic [3:0]         n_ext;
    logic               have;
    logic [4:0]         ndrop;
    phase_t             ph_n;
    logic [8:0]         sym;
    logic               sym_vld;
    logic               lit;
    logic               start_copy;
    logic [8:0]         len_v;
    logic [DIST_W-1:0]  dist_v;
    logic [1:0]         err_set;
    logic               done_set;

    assign aligned = buf_reg << (5'd24 - held_reg);
    assign top9    = aligned[23:15];
    assign ext13   = aligned[23:11] >> (4'd13 - n_ext);
    assign len_v   = len_base(len_idx_reg) + 9'(ext13);
    assign dist_v  = dist_base(dist_idx_reg) + DIST_W'(ext13);

    always_comb begin
        have       = 1'b0;
        ndrop      = 5'd0;
        ph_n       = phase_reg;
        sym        = 9'd0;
        sym_vld    = 1'b0;
        lit        = 1'b0;
        start_copy = 1'b0;
        err_set    = ERR_NONE;
        done_set   = 1'b0;
        n_ext      = 4'd0;
        unique case (phase_reg)
            PH_HEADER: begin
                if (held_reg >= 5'd3) begin
                    have  = 1'b1;
                    ndrop = 5'd3;
                    ph_n  = PH_CODE;
                end
            end
            PH_CODE: begin
                // 7-bit, 8-bit and 9-bit codes of the fixed alphabet
                if (held_reg >= 5'd7) begin
                    if (top9[8:2] <= 7'h17) begin
                        have = 1'b1; ndrop = 5'd7; sym_vld = 1'b1;
                        sym  = 9'd256 + 9'(top9[8:2]);
                    end else if (held_reg >= 5'd8) begin
                        if (top9[8:1] >= 8'h30 && top9[8:1] <= 8'hbf) begin
                            have = 1'b1; ndrop = 5'd8; sym_vld = 1'b1;
                            sym  = 9'(top9[8:1]) - 9'h30;
                        end else if (top9[8:1] >= 8'hc0 && top9[8:1] <= 8'hc7) begin
                            have = 1'b1; ndrop = 5'd8; sym_vld = 1'b1;
                            sym  = 9'd280 + 9'(top9[8:1] - 8'hc0);
                        end else if (held_reg >= 5'd9) begin
                            have = 1'b1; ndrop = 5'd9; sym_vld = 1'b1;
                            sym  = 9'd144 + (top9 - 9'h190);
                        end
                    end
                end
                if (sym_vld) begin
                    if (sym < 9'd256) begin
                        lit = 1'b1;
                    end else if (sym == 9'd256) begin
                        done_set = 1'b1;
                        ph_n     = PH_DONE;
                    end else if (sym <= 9'd285) begin
                        ph_n = PH_LEN_EXTRA;
                    end else begin
                        err_set = ERR_SYM;
                        ph_n    = PH_HALT;
                    end
                end
            end
            PH_LEN_EXTRA: begin
                n_ext = len_extra(len_idx_reg);
                if (held_reg >= 5'(n_ext)) begin
                    have  = 1'b1;
                    ndrop = 5'(n_ext);
                    ph_n  = PH_DIST_CODE;
                end
            end
            PH_DIST_CODE: begin
                if (held_reg >= 5'd5) begin
                    have  = 1'b1;
                    ndrop = 5'd5;
                    if (top9[8:4] >= 5'd30) begin
                        err_set = ERR_DCODE;
                        ph_n    = PH_HALT;
                    end else begin
                        ph_n = PH_DIST_EXTRA;
                    end
                end
            end
            PH_DIST_EXTRA: begin
                n_ext = dist_extra(dist_idx_reg);
                if (held_reg >= 5'(n_ext)) begin
                    have  = 1'b1;
                    ndrop = 5'(n_ext);
                    if (dist_v > prod_reg || dist_v > DIST_W'(WINDOW_BYTES)) begin
                        err_set = ERR_FAR;
                        ph_n    = PH_HALT;
                    end else begin
                        start_copy = 1'b1;
                        ph_n       = PH_CODE;
                    end
                end
            end
            PH_DONE, PH_HALT: begin
                have = 1'b0;
            end
            default: have = 1'b0;
        endcase
    end

    // ---------------- byte store and packing ----------------
    logic       out_free;
    logic       stage_ok;
    logic       pack_full;
    logic       put_ok;
    logic       put_en;
    logic [7:0] put_byte;
    logic       step_fire;
    logic       push_mid;
    logic       flush_need;
    logic       push_end;
    logic [4:0] held_drop;
    logic       cpy_src_ok;

    assign out_free   = !o_valid_reg || m_tready;
    assign stage_ok   = stage_cnt_reg < STAGE_W'(STAGE_CAP);
    assign pack_full  = pack_cnt_reg == CNT_W'(OUT_LANES);
    assign put_ok     = !(stage_ok && pack_full) || out_free;
    assign step_fire  = cmd.step && have && !(lit && !put_ok);
    assign cpy_src_ok = {7'd0, cpy_i_reg} < dist_reg;
    assign put_en     = (step_fire && lit) || (cmd.cpy_wr && put_ok);
    assign put_byte   = cmd.cpy_wr ? (cpy_src_ok ? ram_rd : last_byte_reg) : sym[7:0];
    assign push_mid   = put_en && stage_ok && pack_full;
    assign flush_need = (pack_cnt_reg != '0) || done_reg || (err_reg != ERR_NONE);
    assign push_end   = cmd.flush && flush_need && out_free;
    assign held_drop  = held_reg - ndrop;

    // history: read the byte before the match, then the match source
    assign ram_raddr = (cmd.cpy_rd || cmd.cpy_wr) ? (src_reg + WIN_AW'(cpy_i_reg))
                                                  : (wr_idx_reg - WIN_AW'(1));

    lzfd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (put_en),
        .wr_addr (wr_idx_reg),
        .wr_data (put_byte),
        .rd_addr (ram_raddr),
        .rd_data (ram_rd)
    );

    // accepted byte: restart first, then append to the bit buffer
    logic [23:0] ld_buf;
    logic [4:0]  ld_held;
    phase_t      ld_phase;
    logic        ld_go;

    assign ld_buf   = in_start ? 24'd0 : buf_reg;
    assign ld_held  = in_start ? 5'd0 : held_reg;
    assign ld_phase = in_start ? PH_HEADER : phase_reg;
    assign ld_go    = !(ld_phase == PH_DONE || ld_phase == PH_HALT);

    // stream state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg      <= '0;
            held_reg     <= '0;
            phase_reg    <= PH_HEADER;
            len_idx_reg  <= '0;
            mlen_reg     <= '0;
            dist_idx_reg <= '0;
            wr_idx_reg   <= '0;
            prod_reg     <= '0;
        end else if (cmd.load) begin
            phase_reg <= ld_phase;
            if (in_start) begin
                len_idx_reg  <= '0;
                mlen_reg     <= '0;
                dist_idx_reg <= '0;
                wr_idx_reg   <= '0;
                prod_reg     <= '0;
            end
            if (ld_go) begin
                buf_reg  <= {ld_buf[15:0], in_byte};
                held_reg <= (ld_held > 5'd16) ? 5'd24 : ld_held + 5'd8;
            end else begin
                buf_reg  <= ld_buf;
                held_reg <= ld_held;
            end
        end else begin
            if (step_fire) begin
                phase_reg <= ph_n;
                held_reg  <= held_drop;
                buf_reg   <= buf_reg & ((24'd1 << held_drop) - 24'd1);
                if (phase_reg == PH_CODE) begin
                    len_idx_reg <= 5'(sym - 9'd257);
                end
                if (phase_reg == PH_LEN_EXTRA) begin
                    mlen_reg <= (len_v > 9'(MAX_MATCH)) ? 9'(MAX_MATCH) : len_v;
                end
                if (phase_reg == PH_DIST_CODE) begin
                    dist_idx_reg <= top9[8:4];
                end
            end
            if (put_en) begin
                wr_idx_reg <= wr_idx_reg + WIN_AW'(1);
                if (prod_reg != '1) begin
                    prod_reg <= prod_reg + PROD_W'(1);
                end
            end
        end
    end

    // match copy counters
    always_ff @(posedge aclk) begin
        if (step_fire && start_copy) begin
            dist_reg  <= dist_v;
            src_reg   <= wr_idx_reg - WIN_AW'(dist_v);
            cpy_i_reg <= '0;
        end else if (cmd.cpy_wr && put_ok) begin
            cpy_i_reg <= cpy_i_reg + 9'd1;
        end
        if (cmd.cpy_rd && cpy_i_reg == '0) begin
            last_byte_reg <= ram_rd;
        end
    end

    // packing of decoded bytes for the current input byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_cnt_reg  <= '0;
            stage_cnt_reg <= '0;
            done_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
        end else if (cmd.load) begin
            pack_cnt_reg  <= '0;
            stage_cnt_reg <= '0;
            done_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
        end else begin
            if (step_fire) begin
                if (done_set) begin
                    done_reg <= 1'b1;
                end
                if (err_set != ERR_NONE) begin
                    err_reg <= err_set;
                end
            end
            if (put_en && stage_ok) begin
                stage_cnt_reg <= stage_cnt_reg + STAGE_W'(1);
                pack_cnt_reg  <= pack_full ? CNT_W'(1) : pack_cnt_reg + CNT_W'(1);
            end
            if (push_end) begin
                pack_cnt_reg <= '0;
            end
        end
    end

    // lane data; unused lanes are kept at zero
    always_ff @(posedge aclk) begin
        if (cmd.load || push_end) begin
            for (int i = 0; i < OUT_LANES; i++) begin
                lanes_reg[i] <= '0;
            end
        end else if (put_en && stage_ok) begin
            if (pack_full) begin
                for (int i = 1; i < OUT_LANES; i++) begin
                    lanes_reg[i] <= '0;
                end
                lanes_reg[0] <= put_byte;
            end else begin
                lanes_reg[pack_cnt_reg[LANE_IW-1:0]] <= put_byte;
            end
        end
    end

    // output register
    logic [8*OUT_LANES-1:0] lanes_flat;

    always_comb begin
        for (int i = 0; i < OUT_LANES; i++) begin
            lanes_flat[8*i +: 8] = lanes_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (push_mid || push_end) begin
            o_valid_reg <= 1'b1;
        end else if (m_tready) begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_mid || push_end) begin
            o_data_reg <= lanes_flat;
            o_cnt_reg  <= pack_cnt_reg;
            o_done_reg <= push_end && done_reg;
            o_err_reg  <= push_end ? err_reg : ERR_NONE;
            o_last_reg <= push_end;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{(72 - 8*OUT_LANES - CNT_W){1'b0}}, o_cnt_reg, o_data_reg};
    assign m_tuser  = {o_err_reg, o_done_reg};
    assign m_tlast  = o_last_reg;

    // status
    always_comb begin
        stat            = '0;
        stat.load_go    = ld_go;
        stat.step_end   = !have;
        stat.step_copy  = step_fire && start_copy;
        stat.put_ok     = put_ok;
        stat.copy_last  = (cpy_i_reg + 9'd1) == mlen_reg;
        stat.flush_done = !flush_need || out_free;
    end

endmodule

// ===== src/lz77_fixed_code_decompressor_core.sv =====
// Top level of the fixed-code LZ77 decompressor: controller plus datapath.
// Depends on lzfd_pkg, lzfd_ctrl, lzfd_datapath, lzfd_ram.
`timescale 1ns / 1ps

// Compressed bytes enter one per transaction on s_, bits used MSB first; a
// stream starts with a 3-bit header, then fixed-code literals, matches and an
// end code. Decoded bytes leave on m_ packed up to eight per transaction, with
// tlast on the final transaction caused by each input byte. An input byte
// is taken while idle, then decoded one symbol phase per step (header, code,
// length extra, distance code, distance extra); each copied match byte is one
// read and one write of the 32 KiB history RAM. A closing result, if any, is
// then handed to the output register, which lets decoding continue while a
// result waits. After end of block or an error the stream is halted until an
// input with stream_start set. The history needs no clearing after reset.
module lz77_fixed_code_decompressor_core
    import lzfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] stream_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] out_bytes, [67:64] byte_count, zero pad
    output logic [2:0]  m_tuser,   // [0] stream_done, [2:1] error_code
    output logic        m_tlast    // last_of_run
);

    lzfd_cmd_t  cmd;
    lzfd_stat_t stat;

    lzfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lzfd_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_byte  (s_tdata),
        .in_start (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a result that is not the last of its input byte is always full
    a_mid_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[67:64] == 4'(OUT_LANES))
        else $error("non-final result not full");

    // end and error flags only on the closing result
    a_flag_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 3'd0 |-> m_tlast)
        else $error("flag on non-final result");

    // end of block and error never together
    a_done_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:1] != ERR_NONE |-> !m_tuser[0])
        else $error("done and error both set");

    // no input taken while results of the previous byte are still produced
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step || cmd.cpy_rd || cmd.cpy_wr || cmd.flush |-> !s_tready)
        else $error("input ready while busy");

endmodule

// ===== test/tb_lz77_fixed_code_decompressor_core.sv =====
// Testbench for lz77_fixed_code_decompressor_core: encodes fixed-code streams,
// predicts the decoded result transactions and checks them on the m_ channel.
// Depends on lzfd_pkg and the decompressor RTL.
`timescale 1ns / 1ps

module tb_lz77_fixed_code_decompressor_core;
    import lzfd_pkg::*;

    typedef struct {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        done;
        logic [1:0]  err;
        logic        last;
    } dec_word_t;

    typedef enum int {
        FIN_END, FIN_BADSYM, FIN_BADDIST, FIN_FAR, FIN_OPEN
    } stream_fin_t;

    localparam int WIN = 32768;

    // symbol tables of the fixed alphabet
    localparam int LBASE [0:28] = '{3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19,
        23, 27, 31, 35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258};
    localparam int LEXT [0:28] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2,
        2, 3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0};
    localparam int DBASE [0:29] = '{1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65,
        97, 129, 193, 257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145,
        8193, 12289, 16385, 24577};
    localparam int DEXT [0:29] = '{0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6,
        6, 7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;   // [63:0] out_bytes, [67:64] byte_count, zero pad
    logic [2:0]  m_tuser;   // [0] stream_done, [2:1] error_code
    logic        m_tlast;

    lz77_fixed_code_decompressor_core dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // decoder shadow state
    logic [7:0] hist [0:WIN-1];
    int         wr_idx, produced, bitbuf, held, len_idx, match_len, dist_idx;
    phase_t     phase;

    dec_word_t  pending_words[$];
    int         fails = 0;
    int         items = 0;
    int         send_idle = 0, recv_idle = 0;

    // encoder state
    bit         enc_bits[$];
    int         enc_produced;

    task automatic report(input string what);
        fails++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic int peek(input int n);
        return (bitbuf >> (held - n)) & ((1 << n) - 1);
    endfunction

    function automatic void drop(input int n);
        held -= n;
        bitbuf &= (1 << held) - 1;
    endfunction

    function automatic void restart();
        wr_idx = 0; produced = 0; phase = PH_HEADER;
        bitbuf = 0; held = 0; len_idx = 0; match_len = 0; dist_idx = 0;
    endfunction

    // decode one accepted compressed byte into expected result words
    function automatic void decode_byte(input logic [7:0] b, input logic st);
        logic [7:0] staged[$];
        logic [7:0] lastb, c;
        dec_word_t  w;
        int         v, n, sym, src, nres, idx;
        logic       done, go;
        logic [1:0] err;
        done = 1'b0; err = ERR_NONE; go = 1'b1;
        if (st) restart();
        if (phase == PH_DONE || phase == PH_HALT) return;
        bitbuf = ((bitbuf << 8) | b) & 24'hFFFFFF;
        held += 8;
        if (held > 24) held = 24;
        while (go && phase != PH_DONE && phase != PH_HALT) begin
            case (phase)
                PH_HEADER: begin
                    if (held < 3) go = 1'b0;
                    else begin drop(3); phase = PH_CODE; end
                end
                PH_CODE: begin
                    sym = -1;
                    if (held < 7) go = 1'b0;
                    else if (peek(7) <= 'h17) begin
                        sym = 256 + peek(7); drop(7);
                    end else if (held < 8) go = 1'b0;
                    else if (peek(8) >= 'h30 && peek(8) <= 'hbf) begin
                        sym = peek(8) - 'h30; drop(8);
                    end else if (peek(8) >= 'hc0 && peek(8) <= 'hc7) begin
                        sym = 280 + peek(8) - 'hc0; drop(8);
                    end else if (held < 9) go = 1'b0;
                    else begin
                        sym = 144 + peek(9) - 'h190; drop(9);
                    end
                    if (sym >= 0 && sym < 256) begin
                        hist[wr_idx] = sym[7:0];
                        wr_idx = (wr_idx + 1) % WIN;
                        if (produced < 65535) produced++;
                        if (staged.size() < STAGE_CAP) staged.push_back(sym[7:0]);
                    end else if (sym == 256) begin
                        done = 1'b1; phase = PH_DONE;
                    end else if (sym > 256 && sym <= 285) begin
                        len_idx = sym - 257; phase = PH_LEN_EXTRA;
                    end else if (sym > 285) begin
                        err = ERR_SYM; phase = PH_HALT;
                    end
                end
                PH_LEN_EXTRA: begin
                    n = LEXT[len_idx];
                    if (held < n) go = 1'b0;
                    else begin
                        v = LBASE[len_idx] + peek(n); drop(n);
                        match_len = (v > 258) ? 258 : v;
                        phase = PH_DIST_CODE;
                    end
                end
                PH_DIST_CODE: begin
                    if (held < 5) go = 1'b0;
                    else begin
                        v = peek(5); drop(5);
                        if (v >= 30) begin err = ERR_DCODE; phase = PH_HALT; end
                        else begin dist_idx = v; phase = PH_DIST_EXTRA; end
                    end
                end
                default: begin
                    n = DEXT[dist_idx];
                    if (held < n) go = 1'b0;
                    else begin
                        v = DBASE[dist_idx] + peek(n); drop(n);
                        if (v > produced || v > WIN) begin
                            err = ERR_FAR; phase = PH_HALT;
                        end else begin
                            // overlapping part repeats the byte before the match
                            lastb = hist[(wr_idx + WIN - 1) % WIN];
                            src = (wr_idx + WIN - v) % WIN;
                            for (int i = 0; i < match_len; i++) begin
                                c = (i < v) ? hist[(src + i) % WIN] : lastb;
                                hist[wr_idx] = c;
                                wr_idx = (wr_idx + 1) % WIN;
                                if (produced < 65535) produced++;
                                if (staged.size() < STAGE_CAP) staged.push_back(c);
                            end
                            phase = PH_CODE;
                        end
                    end
                end
            endcase
        end
        nres = (staged.size() + OUT_LANES - 1) / OUT_LANES;
        if (nres == 0 && (done || err != ERR_NONE)) nres = 1;
        for (int k = 0; k < nres; k++) begin
            w.bytes = '0; w.count = '0;
            for (int j = 0; j < OUT_LANES; j++) begin
                idx = k * OUT_LANES + j;
                if (idx < staged.size()) begin
                    w.bytes[8*j +: 8] = staged[idx];
                    w.count++;
                end
            end
            w.last = (k + 1 == nres);
            w.done = w.last ? done : 1'b0;
            w.err  = w.last ? err : ERR_NONE;
            pending_words.push_back(w);
        end
    endfunction

    // one input transaction, with random hold-off before it
    task automatic send_byte(input logic [7:0] b, input logic st);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, st);
        items++;
    endtask

    // receiver stalls
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    // result checker
    always @(posedge aclk) begin
        dec_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) report("result with nothing expected");
            else begin
                w = pending_words.pop_front();
                if (m_tdata[63:0] !== w.bytes)
                    report($sformatf("out_bytes %h exp %h", m_tdata[63:0], w.bytes));
                if (m_tdata[67:64] !== w.count)
                    report($sformatf("byte_count %0d exp %0d", m_tdata[67:64], w.count));
                if (m_tuser[0] !== w.done)
                    report($sformatf("stream_done %b exp %b", m_tuser[0], w.done));
                if (m_tuser[2:1] !== w.err)
                    report($sformatf("error_code %0d exp %0d", m_tuser[2:1], w.err));
                if (m_tlast !== w.last)
                    report($sformatf("tlast %b exp %b", m_tlast, w.last));
            end
        end
    end

    // ---------------- stream encoder ----------------
    function automatic void put_bits(input int val, input int n);
        for (int i = n - 1; i >= 0; i--) enc_bits.push_back(val[i]);
    endfunction

    function automatic void put_lit(input int v);
        if (v < 144) put_bits('h30 + v, 8);
        else put_bits('h190 + v - 144, 9);
        enc_produced++;
    endfunction

    function automatic void put_sym(input int sym);
        if (sym < 280) put_bits(sym - 256, 7);
        else put_bits('hc0 + sym - 280, 8);
    endfunction

    function automatic void put_match(input int len, input int mdist);
        int li, di;
        li = 0; di = 0;
        for (int i = 0; i < 28; i++) if (LBASE[i] <= len) li = i;
        if (len == 258 && $urandom_range(1)) li = 28;
        put_sym(257 + li);
        put_bits(len - LBASE[li], LEXT[li]);
        for (int i = 0; i < 30; i++) if (DBASE[i] <= mdist) di = i;
        put_bits(di, 5);
        put_bits(mdist - DBASE[di], DEXT[di]);
        enc_produced += len;
    endfunction

    function automatic void open_stream();
        enc_bits.delete();
        enc_produced = 0;
        put_bits($urandom_range(7), 3);
    endfunction

    function automatic void close_stream(input stream_fin_t fin);
        case (fin)
            FIN_END:     put_sym(256);
            FIN_BADSYM:  put_sym(286 + $urandom_range(1));
            FIN_BADDIST: begin put_sym(257); put_bits(30 + $urandom_range(1), 5); end
            FIN_FAR: begin
                if (enc_produced < WIN) put_match(3, enc_produced + 1);
                else put_sym(256);
            end
            default: ;
        endcase
    endfunction

    // packs the encoded bits into bytes, zero padded; first byte restarts
    task automatic send_stream();
        logic [7:0] b;
        int nbytes;
        nbytes = (enc_bits.size() + 7) / 8;
        for (int i = 0; i < nbytes; i++) begin
            for (int j = 0; j < 8; j++)
                b[7-j] = (i*8 + j < enc_bits.size()) ? enc_bits[i*8 + j] : 1'b0;
            send_byte(b, i == 0);
        end
    endtask

    task automatic drain();
        while (pending_words.size() > 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    // ---------------- tests ----------------
    task automatic test_literals();
        open_stream();
        put_lit(0); put_lit(143); put_lit(144); put_lit(255);
        for (int i = 0; i < 9; i++) put_lit(i * 28);
        close_stream(FIN_END);
        send_stream();
        send_byte(8'hFF, 1'b0);   // ignored after end of block
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_matches();
        open_stream();
        put_lit(65); put_lit(200);
        put_match(3, 1);
        put_match(258, 2);
        put_match(258, 263);
        put_match(10, 5);
        close_stream(FIN_END);
        send_stream();
    endtask

    task automatic test_overlap();
        // match longer than its distance: tail repeats the prior byte
        open_stream();
        put_lit(1); put_lit(2); put_lit(3);
        put_match(12, 3);
        close_stream(FIN_OPEN);
        send_stream();
    endtask

    task automatic test_errors();
        open_stream(); put_lit(7); close_stream(FIN_BADSYM); send_stream();
        send_byte(8'h5A, 1'b0);
        open_stream(); put_lit(7); close_stream(FIN_BADDIST); send_stream();
        open_stream(); close_stream(FIN_FAR); send_stream();
        open_stream(); put_lit(9); put_lit(9); close_stream(FIN_FAR); send_stream();
    endtask

    task automatic test_full_window();
        // fill past the window with short-coded 258-byte matches, then reach
        // back exactly one window
        open_stream();
        put_lit(33); put_lit(150); put_lit(7); put_lit(244);
        for (int i = 0; i < 128; i++) begin
            // length code 285, distance 1..4 without extra bits
            put_sym(285);
            put_bits($urandom_range(3), 5);
            enc_produced += 258;
        end
        put_match(258, WIN);
        close_stream(FIN_FAR);
        send_stream();
    endtask

    task automatic test_random(input int quota);
        int target, nsym, len, mdist;
        stream_fin_t fin;
        target = items + quota;
        while (items < target) begin
            if ($urandom_range(9) == 0) begin
                // noise bytes, start flag random
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), 1'($urandom_range(1)));
            end else begin
                open_stream();
                nsym = $urandom_range(1, 14);
                for (int i = 0; i < nsym; i++) begin
                    if (enc_produced == 0 || $urandom_range(9) < 5)
                        put_lit($urandom_range(255));
                    else begin
                        len = ($urandom_range(15) == 0) ? $urandom_range(3, 258)
                                                         : $urandom_range(3, 20);
                        mdist = $urandom_range(1, enc_produced > WIN ? WIN : enc_produced);
                        put_match(len, mdist);
                    end
                end
                case ($urandom_range(9))
                    0: fin = FIN_BADSYM;
                    1: fin = FIN_BADDIST;
                    2: fin = FIN_FAR;
                    3: fin = FIN_OPEN;
                    default: fin = FIN_END;
                endcase
                close_stream(fin);
                send_stream();
            end
        end
    endtask

    initial begin
        restart();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle = 37; recv_idle = 71;
        test_literals();
        test_matches();
        test_overlap();
        test_errors();
        test_full_window();
        test_random(12);
        send_idle = 71; recv_idle = 37;
        test_random(12);
        send_idle = 0; recv_idle = 0;
        test_random(12);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain();
        if (fails == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
